@@ rtl/selective_reject_receive_window_defines.svh @@
// Assertion macros used by the checker file of the receive window.
`ifndef SELECTIVE_REJECT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REJECT_RECEIVE_WINDOW_DEFINES_SVH

// Plain concurrent check, clocked on clk and disabled during reset.
`define SRRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that looks at the previous cycle, so it is skipped in the cycle after reset.
`define SRRW_ASSERT_SETTLED(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    !$past(rst) && (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/srrw_pkg.sv @@
package srrw_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int LEN_BITS       = 11;
  localparam int SEQ_W          = 32;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int WSIZE_W        = 5;

  // Arriving packet kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_CKERR = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Result kinds.
  localparam logic [1:0] RES_DELIVER = 2'd0;
  localparam logic [1:0] RES_RR      = 2'd1;
  localparam logic [1:0] RES_SREJ    = 2'd2;
  localparam logic [1:0] RES_EOF_ACK = 2'd3;

  // Register indexes, taken from paddr[2].
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [0:0] REG_START_REPLY = 1'b1;

  typedef struct packed {
    logic [1:0]          packet_kind;
    logic [SEQ_W-1:0]    seq_num;
    logic [LEN_BITS-1:0] length;
    logic [SEQ_W-1:0]    payload_ref;
  } packet_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [SEQ_W-1:0]    result_seq;
    logic [LEN_BITS-1:0] result_length;
    logic [SEQ_W-1:0]    result_payload;
    logic [SEQ_W-1:0]    reply_seq;
    logic                last;
  } result_t;

endpackage

@@ rtl/srrw_ram.sv @@
module srrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/selective_reject_receive_window.sv @@
// One item at a time; busy is high only while a data packet is worked. A late one runs
// the shared remainder unit, reads the next slot and picks the reply; an in-order one
// runs it, writes its slot, reads and checks each buffered packet it delivers, then
// picks the reply; one ahead of the expected number runs it, writes a lost marker, runs
// it again and stores the packet. Each result shows for one cycle on a strobe, and the
// receiver cannot hold them off. Reset (rst, synchronous) empties the table, expects one.
module selective_reject_receive_window
  import srrw_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  packet_t             packet,
  output logic                result_strobe,
  output result_t             result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // Width of a count that can hold the window size itself, and of a slot index.
  localparam int WIN_W    = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  // The remainder unit retires this many dividend bits per cycle.
  localparam int MOD_STEP = 4;
  localparam int MOD_CNT  = SEQ_W / MOD_STEP;
  localparam int MCNT_W   = $clog2(MOD_CNT);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MOD      = 4'd1;
  localparam logic [3:0] ST_LOST_WR  = 4'd2;
  localparam logic [3:0] ST_AHEAD_WR = 4'd3;
  localparam logic [3:0] ST_INORD_WR = 4'd4;
  localparam logic [3:0] ST_RUN_RD   = 4'd5;
  localparam logic [3:0] ST_RUN_CHK  = 4'd6;
  localparam logic [3:0] ST_DEC_RD   = 4'd7;
  localparam logic [3:0] ST_DEC      = 4'd8;

  // One slot of the table: the sequence it holds, its length and payload handle.
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [LEN_BITS-1:0] len;
    logic [SEQ_W-1:0]    payload;
  } slot_t;

  logic [3:0]            state;
  logic [3:0]            ret_state;
  packet_t               pkt;
  logic [SEQ_W-1:0]      expected_seq;
  logic [SEQ_W-1:0]      highest_ready;
  logic [SEQ_W-1:0]      reply_counter;
  logic                  finished;
  logic [WSIZE_W-1:0]    window_size;
  logic [SEQ_W-1:0]      start_reply_seq;

  // Shared remainder unit.
  logic [SEQ_W-1:0]      mod_div;
  logic [SEQ_W-1:0]      mod_div_next;
  logic [WIN_W-1:0]      mod_rem;
  logic [WIN_W-1:0]      mod_rem_next;
  logic [MCNT_W-1:0]     mod_cnt;

  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      idx_inc;
  logic [WIN_W-1:0]      run_cnt;
  logic [WIN_W-1:0]      eff_window;

  // Per-slot flags in flip-flops: the packet is buffered, and the entry was written.
  logic [WINDOW_MAX-1:0] full;
  logic [WINDOW_MAX-1:0] written;

  logic                  ram_we;
  slot_t                 ram_wdata;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t                 rd;
  logic                  accept;
  logic                  cfg_we;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // A zero window acts as one slot; anything above the table depth acts as the depth.
  always_comb begin
    if (window_size == '0) begin
      eff_window = WIN_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      eff_window = WIN_W'(WINDOW_MAX);
    end else begin
      eff_window = WIN_W'(window_size);
    end
  end

  // Restoring remainder, MOD_STEP bits a cycle. The partial remainder stays below the
  // divisor, so a single compare and subtract per bit keeps it in range.
  always_comb begin
    logic [WIN_W:0]   t;
    logic [WIN_W-1:0] r;
    logic [SEQ_W-1:0] d;
    r = mod_rem;
    d = mod_div;
    for (int k = 0; k < MOD_STEP; k++) begin
      t = {r, d[SEQ_W-1]};
      d = {d[SEQ_W-2:0], 1'b0};
      if (t >= {1'b0, eff_window}) begin
        t = t - {1'b0, eff_window};
      end
      r = t[WIN_W-1:0];
    end
    mod_rem_next = r;
    mod_div_next = d;
  end

  // Slot of the next sequence number, wrapping at the window size.
  always_comb begin
    logic [WIN_W-1:0] t;
    t = WIN_W'(idx) + WIN_W'(1);
    idx_inc = (t == eff_window) ? '0 : t[IDX_W-1:0];
  end

  // An entry never written reads as all zero, as after reset.
  assign rd = written[idx] ? slot_t'(ram_rdata) : '0;

  // Table writes: a lost marker, or the arriving packet itself.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '{seq: pkt.seq_num, len: pkt.length, payload: pkt.payload_ref};
    case (state)
      ST_LOST_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{seq: expected_seq, len: '0, payload: '0};
      end
      ST_AHEAD_WR, ST_INORD_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  srrw_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (WINDOW_MAX)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ret_state       <= ST_IDLE;
      expected_seq    <= SEQ_W'(1);
      highest_ready   <= '0;
      reply_counter   <= SEQ_W'(3);
      start_reply_seq <= SEQ_W'(3);
      window_size     <= WSIZE_W'(16);
      finished        <= 1'b0;
      full            <= '0;
      written         <= '0;
      result_strobe   <= 1'b0;
      mod_cnt         <= '0;
      run_cnt         <= '0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pkt <= packet;
            if (!finished) begin
              case (packet.packet_kind)
                KIND_EOF: begin
                  // Only an end of file at the expected number is answered; it stops
                  // the block for good.
                  if (packet.seq_num == expected_seq) begin
                    result_strobe <= 1'b1;
                    result        <= '{result_kind: RES_EOF_ACK, result_seq: expected_seq,
                                       result_length: '0, result_payload: '0,
                                       reply_seq: reply_counter, last: 1'b1};
                    finished      <= 1'b1;
                  end
                end
                KIND_DATA: begin
                  mod_rem <= '0;
                  mod_cnt <= '0;
                  state   <= ST_MOD;
                  if (packet.seq_num > expected_seq) begin
                    // Ahead: mark the expected slot lost first, then store the packet.
                    mod_div   <= expected_seq;
                    ret_state <= ST_LOST_WR;
                  end else if (packet.seq_num == expected_seq) begin
                    mod_div   <= packet.seq_num;
                    ret_state <= ST_INORD_WR;
                  end else begin
                    // Late: only the reply decision on the following slot is needed.
                    mod_div   <= expected_seq + SEQ_W'(1);
                    ret_state <= ST_DEC_RD;
                  end
                end
                default: begin
                  // Checksum errors and other flags are dropped.
                end
              endcase
            end
          end
        end
        ST_MOD: begin
          mod_div <= mod_div_next;
          mod_rem <= mod_rem_next;
          mod_cnt <= mod_cnt + MCNT_W'(1);
          if (mod_cnt == MCNT_W'(MOD_CNT - 1)) begin
            idx   <= mod_rem_next[IDX_W-1:0];
            state <= ret_state;
          end
        end
        ST_LOST_WR: begin
          full[idx]    <= 1'b0;
          written[idx] <= 1'b1;
          mod_div      <= pkt.seq_num;
          mod_rem      <= '0;
          mod_cnt      <= '0;
          ret_state    <= ST_AHEAD_WR;
          state        <= ST_MOD;
        end
        ST_AHEAD_WR: begin
          full[idx]     <= 1'b1;
          written[idx]  <= 1'b1;
          result_strobe <= 1'b1;
          result        <= '{result_kind: RES_SREJ, result_seq: expected_seq,
                             result_length: '0, result_payload: '0,
                             reply_seq: reply_counter, last: 1'b1};
          reply_counter <= reply_counter + SEQ_W'(1);
          state         <= ST_IDLE;
        end
        ST_INORD_WR: begin
          full[idx]    <= 1'b1;
          written[idx] <= 1'b1;
          run_cnt      <= '0;
          state        <= ST_RUN_RD;
        end
        ST_RUN_RD: begin
          state <= ST_RUN_CHK;
        end
        ST_RUN_CHK: begin
          // Deliver the contiguous run, at most one window of slots.
          if ((run_cnt < eff_window) && (rd.seq == expected_seq) && full[idx]) begin
            result_strobe <= 1'b1;
            result        <= '{result_kind: RES_DELIVER, result_seq: expected_seq,
                               result_length: rd.len, result_payload: rd.payload,
                               reply_seq: '0, last: 1'b0};
            expected_seq  <= expected_seq + SEQ_W'(1);
            run_cnt       <= run_cnt + WIN_W'(1);
            idx           <= idx_inc;
            state         <= ST_RUN_RD;
          end else begin
            highest_ready <= expected_seq;
            idx           <= idx_inc;
            state         <= ST_DEC_RD;
          end
        end
        ST_DEC_RD: begin
          state <= ST_DEC;
        end
        ST_DEC: begin
          // SREJ when the next slot is a lost marker for the following number, else RR.
          result_strobe <= 1'b1;
          if ((rd.seq == expected_seq + SEQ_W'(1)) && !full[idx]) begin
            result <= '{result_kind: RES_SREJ, result_seq: expected_seq,
                        result_length: '0, result_payload: '0,
                        reply_seq: reply_counter, last: 1'b1};
          end else begin
            result        <= '{result_kind: RES_RR, result_seq: highest_ready,
                               result_length: '0, result_payload: '0,
                               reply_seq: reply_counter, last: 1'b1};
            reply_counter <= reply_counter + SEQ_W'(1);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Register writes must arrive only while the block is idle; the block does not enforce it.
      if (cfg_we) begin
        case (paddr[2:2])
          REG_WINDOW_SIZE: begin
            window_size <= pwdata[WSIZE_W-1:0];
          end
          REG_START_REPLY: begin
            start_reply_seq <= pwdata;
            reply_counter   <= pwdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2:2])
      REG_WINDOW_SIZE: prdata = PDATA_W'(window_size);
      REG_START_REPLY: prdata = start_reply_seq;
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/srrw_checker.sv @@
`include "selective_reject_receive_window_defines.svh"

module srrw_checker
  import srrw_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    result_strobe,
  input result_t result
);

  // A result follows an accepted item or appears while one is in work.
  `SRRW_ASSERT_SETTLED(a_strobe_src, result_strobe, $past(busy) || $past(start), "result without an item")

  // The final result of an item frees the block, earlier ones never do.
  `SRRW_ASSERT(a_last_idle, result_strobe && result.last |-> !busy, "busy after final result")
  `SRRW_ASSERT(a_more_busy, result_strobe && !result.last |-> busy, "idle before final result")

  // Work on an item ends only with its final result.
  `SRRW_ASSERT_SETTLED(a_busy_end, $fell(busy), result_strobe && result.last, "busy dropped without a final result")

endmodule

bind selective_reject_receive_window srrw_checker u_srrw_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .result        (result)
);
